// ===== rtl/gdp_pkg.sv =====
// gdp_pkg: shared constants for the gabor disk pixel pipeline
// register indexes, reset values, fixed-point constants, series step counts and divisor tables
// depends on nothing
package gdp_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_MEAN_LUM    = 3'd0;
   localparam logic [2:0] REG_CONTRAST    = 3'd1;
   localparam logic [2:0] REG_FREQUENCY   = 3'd2;
   localparam logic [2:0] REG_SPREAD_SD   = 3'd3;
   localparam logic [2:0] REG_DISK_RADIUS = 3'd4;

   // register reset values
   localparam logic [7:0]  RST_MEAN_LUM    = 8'd127;
   localparam logic [15:0] RST_CONTRAST    = 16'd0;
   localparam logic [15:0] RST_FREQUENCY   = 16'd6144;
   localparam logic [15:0] RST_SPREAD_SD   = 16'd128;
   localparam logic [15:0] RST_DISK_RADIUS = 16'd256;

   // fixed-point constants
   localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
   localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;
   localparam logic [28:0] EXP_M1_Q30  = 29'd395007542;
   localparam logic [47:0] LEVEL_ONE   = 48'h4000_0000_0000;

   // series step counts
   localparam int EXP_STEPS     = 8;
   localparam int COS_STEPS     = 4;
   localparam int EXP_POW_STEPS = 11;
   localparam logic [4:0] EXP_N_LIMIT = 5'd12;

   // divisors of the exp series (k = 8 down to 1) and their 2^32 reciprocals
   localparam logic [5:0] EXP_DIV [EXP_STEPS] =
      '{6'd8, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1};
   localparam logic [32:0] EXP_RECIP [EXP_STEPS] = '{
      33'(64'h1_0000_0000 / 64'd8), 33'(64'h1_0000_0000 / 64'd7),
      33'(64'h1_0000_0000 / 64'd6), 33'(64'h1_0000_0000 / 64'd5),
      33'(64'h1_0000_0000 / 64'd4), 33'(64'h1_0000_0000 / 64'd3),
      33'(64'h1_0000_0000 / 64'd2), 33'(64'h1_0000_0000 / 64'd1)};

   // divisors of the cosine series and their 2^32 reciprocals
   localparam logic [5:0] COS_DIV [COS_STEPS] = '{6'd56, 6'd30, 6'd12, 6'd2};
   localparam logic [32:0] COS_RECIP [COS_STEPS] = '{
      33'(64'h1_0000_0000 / 64'd56), 33'(64'h1_0000_0000 / 64'd30),
      33'(64'h1_0000_0000 / 64'd12), 33'(64'h1_0000_0000 / 64'd2)};

endpackage

// ===== rtl/gabor_disk_pixel_top.sv =====
// gabor_disk_pixel_top: 76-stage pipeline giving one gray level per coordinate, uses gdp_pkg
// rsp_strobe comes from a valid line that runs beside the data; the envelope
// path (square root, divider, exp series and power steps) sets the pipeline length
// throughput: one pixel per cycle; busy stays low and the receiver cannot stall,
// so the pipeline always advances
// synchronous reset empties the pipeline and loads the register reset values
module gabor_disk_pixel_top #(
   parameter int PHASE_TABLE_SIZE = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_x_pos,
   input  logic signed [15:0] req_y_pos,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_pixel,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int PH_W = $clog2(PHASE_TABLE_SIZE);
   localparam int NUM_W = PH_W + 16;
   localparam logic [32:0] PH_RECIP = 33'(64'h1_0000_0000 / PHASE_TABLE_SIZE);
   localparam int LAT = 75;

   // configuration registers
   logic [7:0]         mean_lum_ff;
   logic signed [15:0] contrast_ff;
   logic [15:0]        frequency_ff;
   logic [15:0]        spread_sd_ff;
   logic [15:0]        disk_radius_ff;
   logic [31:0]        rad_sq_ff;
   logic [15:0]        sdv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_lum_ff    <= gdp_pkg::RST_MEAN_LUM;
         contrast_ff    <= gdp_pkg::RST_CONTRAST;
         frequency_ff   <= gdp_pkg::RST_FREQUENCY;
         spread_sd_ff   <= gdp_pkg::RST_SPREAD_SD;
         disk_radius_ff <= gdp_pkg::RST_DISK_RADIUS;
      end else if (csr_we) begin
         case (csr_index)
            gdp_pkg::REG_MEAN_LUM:    mean_lum_ff    <= csr_wdata[7:0];
            gdp_pkg::REG_CONTRAST:    contrast_ff    <= csr_wdata;
            gdp_pkg::REG_FREQUENCY:   frequency_ff   <= csr_wdata;
            gdp_pkg::REG_SPREAD_SD:   spread_sd_ff   <= csr_wdata;
            gdp_pkg::REG_DISK_RADIUS: disk_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // squared radius is registered from the radius register and follows it in the next cycle
   always_ff @(posedge clock) begin
      rad_sq_ff <= 32'(disk_radius_ff) * 32'(disk_radius_ff);
   end

   // zero spread acts as one step
   assign sdv = (spread_sd_ff == 16'd0) ? 16'd1 : spread_sd_ff;

   // valid line, one bit per stage
   logic vld_ff [LAT+1];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAT; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= start & ~busy;
         for (int k = 1; k <= LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // input register, stage 0
   logic [15:0] x0_ff, y0_ff;
   always_ff @(posedge clock) begin
      x0_ff <= req_x_pos;
      y0_ff <= req_y_pos;
   end

   // ---------------- envelope path ----------------

   // squares, stage 1
   logic signed [31:0] xx_in, yy_in;
   logic [30:0]        xx_ff, yy_ff;
   assign xx_in = $signed(x0_ff) * $signed(x0_ff);
   assign yy_in = $signed(y0_ff) * $signed(y0_ff);

   // radius squared and disk test, stage 2
   logic [31:0] s_in, s_ff;
   logic        inside_ff;
   assign s_in = 32'(xx_ff) + 32'(yy_ff);

   always_ff @(posedge clock) begin
      xx_ff     <= xx_in[30:0];
      yy_ff     <= yy_in[30:0];
      s_ff      <= s_in;
      inside_ff <= s_in < rad_sq_ff;
   end

   // integer square root, one result bit per stage (stages 3..18)
   logic [31:0] sv_ff [16];
   logic [31:0] sr_ff [16];
   logic [31:0] sv_in [16];
   logic [31:0] sr_in [16];
   logic [31:0] sv_src [16];
   logic [31:0] sr_src [16];
   logic [31:0] sq_bit [16];
   logic [31:0] sq_try [16];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sv_src[i] = (i == 0) ? s_ff : sv_ff[(i == 0) ? 0 : i-1];
         sr_src[i] = (i == 0) ? 32'd0 : sr_ff[(i == 0) ? 0 : i-1];
         sq_bit[i] = 32'd1 << (2 * (15 - i));
         sq_try[i] = sr_src[i] + sq_bit[i];
         if (sv_src[i] >= sq_try[i]) begin
            sv_in[i] = sv_src[i] - sq_try[i];
            sr_in[i] = (sr_src[i] >> 1) + sq_bit[i];
         end else begin
            sv_in[i] = sv_src[i];
            sr_in[i] = sr_src[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         sv_ff[i] <= sv_in[i];
         sr_ff[i] <= sr_in[i];
      end
   end

   // distance beyond the disk edge and divider range check, stage 19
   logic [15:0] d_in, d_ff;
   logic        ovf_ff;
   assign d_in = sr_ff[15][15:0] - disk_radius_ff;

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      ovf_ff <= {3'b000, d_in} >= {sdv, 3'b000};
   end

   // restoring divider, one quotient bit per stage (stages 20..34)
   logic [27:0] qr_ff [15];
   logic [14:0] qq_ff [15];
   logic [27:0] qr_in [15];
   logic [14:0] qq_in [15];
   logic [27:0] qr_src [15];
   logic [14:0] qq_src [15];
   logic [30:0] qdv [15];

   always_comb begin
      for (int i = 0; i < 15; i++) begin
         qr_src[i] = (i == 0) ? {d_ff, 12'd0} : qr_ff[(i == 0) ? 0 : i-1];
         qq_src[i] = (i == 0) ? 15'd0 : qq_ff[(i == 0) ? 0 : i-1];
         qdv[i]    = 31'(sdv) << (14 - i);
         if ({3'b000, qr_src[i]} >= qdv[i]) begin
            qr_in[i] = qr_src[i] - qdv[i][27:0];
            qq_in[i] = {qq_src[i][13:0], 1'b1};
         end else begin
            qr_in[i] = qr_src[i];
            qq_in[i] = {qq_src[i][13:0], 1'b0};
         end
      end
   end

   // range flag follows the divider
   logic ov_ff [15];

   always_ff @(posedge clock) begin
      ov_ff[0] <= ovf_ff;
      for (int i = 1; i < 15; i++) ov_ff[i] <= ov_ff[i-1];
      for (int i = 0; i < 15; i++) begin
         qr_ff[i] <= qr_in[i];
         qq_ff[i] <= qq_in[i];
      end
   end

   // exponent e = z^2 / 2^13 and cutoff, stage 35
   logic [29:0] zz;
   logic [16:0] e_in, e_ff;
   logic        zero_ff;
   assign zz   = 30'(qq_ff[14]) * 30'(qq_ff[14]);
   assign e_in = zz[29:13];

   always_ff @(posedge clock) begin
      e_ff    <= e_in;
      zero_ff <= ov_ff[14] | (e_in[16:12] >= gdp_pkg::EXP_N_LIMIT);
   end

   // side lines: fraction, cutoff flag with integer part, disk flag
   logic [29:0] fl_ff [21];
   logic [5:0]  nz_ff [35];
   logic        ins_ff [68];

   always_ff @(posedge clock) begin
      fl_ff[0] <= {e_ff[11:0], 18'd0};
      for (int k = 1; k < 21; k++) fl_ff[k] <= fl_ff[k-1];
      nz_ff[0] <= {zero_ff, e_ff[16:12]};
      for (int k = 1; k < 35; k++) nz_ff[k] <= nz_ff[k-1];
      ins_ff[0] <= inside_ff;
      for (int k = 1; k < 68; k++) ins_ff[k] <= ins_ff[k-1];
   end

   // exp(-fraction) series, three stages a term (stages 36..59)
   logic signed [31:0] ep_src [gdp_pkg::EXP_STEPS];
   logic [31:0]        ex_src [gdp_pkg::EXP_STEPS];
   logic [62:0]        ea_prod [gdp_pkg::EXP_STEPS];
   logic [64:0]        eb_prod [gdp_pkg::EXP_STEPS];
   logic [31:0]        ec_rem [gdp_pkg::EXP_STEPS];
   logic [31:0]        ec_q [gdp_pkg::EXP_STEPS];
   logic signed [31:0] ec_p_in [gdp_pkg::EXP_STEPS];
   logic [31:0]        ea_m_ff [gdp_pkg::EXP_STEPS];
   logic [31:0]        eb_m_ff [gdp_pkg::EXP_STEPS];
   logic [31:0]        eb_q0_ff [gdp_pkg::EXP_STEPS];
   logic signed [31:0] ec_p_ff [gdp_pkg::EXP_STEPS];

   always_comb begin
      for (int j = 0; j < gdp_pkg::EXP_STEPS; j++) begin
         if (j == 0) begin
            ep_src[j] = gdp_pkg::Q30_ONE;
            ex_src[j] = {2'b00, e_ff[11:0], 18'd0};
         end else begin
            ep_src[j] = ec_p_ff[(j == 0) ? 0 : j-1];
            ex_src[j] = {2'b00, fl_ff[(j == 0) ? 0 : 3*j-1]};
         end
         ea_prod[j] = 63'(ex_src[j]) * 63'(ep_src[j][30:0]);
         eb_prod[j] = 65'(ea_m_ff[j]) * 65'(gdp_pkg::EXP_RECIP[j]);
         ec_rem[j]  = eb_m_ff[j] - eb_q0_ff[j] * {26'd0, gdp_pkg::EXP_DIV[j]};
         ec_q[j]    = eb_q0_ff[j]
                      + ((ec_rem[j] >= {26'd0, gdp_pkg::EXP_DIV[j]}) ? 32'd1 : 32'd0);
         ec_p_in[j] = $signed(gdp_pkg::Q30_ONE - ec_q[j]);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < gdp_pkg::EXP_STEPS; j++) begin
         ea_m_ff[j]  <= ea_prod[j][61:30];
         eb_m_ff[j]  <= ea_m_ff[j];
         eb_q0_ff[j] <= eb_prod[j][63:32];
         ec_p_ff[j]  <= ec_p_in[j];
      end
   end

   // multiply by exp(-1) once per unit of the integer part (stages 60..70)
   logic [30:0] xp_src [gdp_pkg::EXP_POW_STEPS];
   logic [59:0] xp_prod [gdp_pkg::EXP_POW_STEPS];
   logic [30:0] xp_in [gdp_pkg::EXP_POW_STEPS];
   logic [30:0] xp_ff [gdp_pkg::EXP_POW_STEPS];

   always_comb begin
      for (int i = 0; i < gdp_pkg::EXP_POW_STEPS; i++) begin
         xp_src[i]  = (i == 0) ? ec_p_ff[gdp_pkg::EXP_STEPS-1][30:0]
                               : xp_ff[(i == 0) ? 0 : i-1];
         xp_prod[i] = 60'(xp_src[i]) * 60'(gdp_pkg::EXP_M1_Q30);
         xp_in[i]   = (5'(i) < nz_ff[23+i][4:0]) ? {1'b0, xp_prod[i][59:30]} : xp_src[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < gdp_pkg::EXP_POW_STEPS; i++) xp_ff[i] <= xp_in[i];
   end

   // envelope in Q16, stage 71
   logic [16:0] env_in, env_ff;
   always_comb begin
      if (ins_ff[67]) begin
         env_in = 17'h10000;
      end else if (nz_ff[34][5]) begin
         env_in = 17'd0;
      end else begin
         env_in = xp_ff[gdp_pkg::EXP_POW_STEPS-1][30:14];
      end
   end

   always_ff @(posedge clock) begin
      env_ff <= env_in;
   end

   // ---------------- grating path ----------------

   // phase fraction, stage 1
   logic [31:0] ph_full;
   logic [19:0] ph_ff;
   assign ph_full = 32'($signed(x0_ff)) * 32'(frequency_ff);

   // phase index, stage 2
   logic [32:0]     idx_full;
   logic [PH_W-1:0] idx_ff;
   assign idx_full = 33'(ph_ff) * 33'(PHASE_TABLE_SIZE);

   // index to Q0.16 cycles by reciprocal, stages 3 and 4
   logic [NUM_W-1:0]    num3_ff;
   logic [NUM_W+32:0]   u_prod;
   logic [15:0]         uq0_ff;
   logic [31:0]         u_rem;
   logic [15:0]         u_in, u_ff;
   assign u_prod = (NUM_W+33)'({idx_ff, 16'd0}) * (NUM_W+33)'(PH_RECIP);
   assign u_rem  = 32'(num3_ff) - 32'(uq0_ff) * 32'(PHASE_TABLE_SIZE);
   assign u_in   = uq0_ff + ((u_rem >= 32'(PHASE_TABLE_SIZE)) ? 16'd1 : 16'd0);

   // quadrant fold, stage 5
   logic [14:0] arg_in, arg_ff;
   logic        neg_ff;
   assign arg_in = u_ff[14] ? (15'd16384 - {1'b0, u_ff[13:0]}) : {1'b0, u_ff[13:0]};

   // angle and its square, stages 6 and 7
   logic [45:0] w_full;
   logic [31:0] w_ff;
   logic [61:0] w2_full;
   logic [31:0] w2_ff;
   assign w_full  = 46'(arg_ff) * 46'(gdp_pkg::TWO_PI_Q28);
   assign w2_full = 62'(w_ff[30:0]) * 62'(w_ff[30:0]);

   always_ff @(posedge clock) begin
      ph_ff   <= ph_full[19:0];
      idx_ff  <= idx_full[20 +: PH_W];
      num3_ff <= {idx_ff, 16'd0};
      uq0_ff  <= u_prod[47:32];
      u_ff    <= u_in;
      arg_ff  <= arg_in;
      neg_ff  <= u_ff[15] ^ u_ff[14];
      w_ff    <= w_full[45:14];
      w2_ff   <= w2_full[61:30];
   end

   // side lines: squared angle and sign
   logic [31:0] wl_ff [9];
   logic        ng_ff [14];

   always_ff @(posedge clock) begin
      wl_ff[0] <= w2_ff;
      for (int k = 1; k < 9; k++) wl_ff[k] <= wl_ff[k-1];
      ng_ff[0] <= neg_ff;
      for (int k = 1; k < 14; k++) ng_ff[k] <= ng_ff[k-1];
   end

   // cosine series, three stages a term (stages 8..19)
   logic signed [31:0] cp_src [gdp_pkg::COS_STEPS];
   logic [31:0]        cx_src [gdp_pkg::COS_STEPS];
   logic [62:0]        ca_prod [gdp_pkg::COS_STEPS];
   logic [64:0]        cb_prod [gdp_pkg::COS_STEPS];
   logic [31:0]        cc_rem [gdp_pkg::COS_STEPS];
   logic [31:0]        cc_q [gdp_pkg::COS_STEPS];
   logic signed [31:0] cc_p_in [gdp_pkg::COS_STEPS];
   logic [31:0]        ca_m_ff [gdp_pkg::COS_STEPS];
   logic [31:0]        cb_m_ff [gdp_pkg::COS_STEPS];
   logic [31:0]        cb_q0_ff [gdp_pkg::COS_STEPS];
   logic signed [31:0] cc_p_ff [gdp_pkg::COS_STEPS];

   always_comb begin
      for (int j = 0; j < gdp_pkg::COS_STEPS; j++) begin
         if (j == 0) begin
            cp_src[j] = gdp_pkg::Q30_ONE;
            cx_src[j] = w2_ff;
         end else begin
            cp_src[j] = cc_p_ff[(j == 0) ? 0 : j-1];
            cx_src[j] = wl_ff[(j == 0) ? 0 : 3*j-1];
         end
         ca_prod[j] = 63'(cx_src[j]) * 63'(cp_src[j][30:0]);
         cb_prod[j] = 65'(ca_m_ff[j]) * 65'(gdp_pkg::COS_RECIP[j]);
         cc_rem[j]  = cb_m_ff[j] - cb_q0_ff[j] * {26'd0, gdp_pkg::COS_DIV[j]};
         cc_q[j]    = cb_q0_ff[j]
                      + ((cc_rem[j] >= {26'd0, gdp_pkg::COS_DIV[j]}) ? 32'd1 : 32'd0);
         cc_p_in[j] = $signed(gdp_pkg::Q30_ONE - cc_q[j]);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < gdp_pkg::COS_STEPS; j++) begin
         ca_m_ff[j]  <= ca_prod[j][61:30];
         cb_m_ff[j]  <= ca_m_ff[j];
         cb_q0_ff[j] <= cb_prod[j][63:32];
         cc_p_ff[j]  <= cc_p_in[j];
      end
   end

   // clamp at zero, Q1.15 with sign, stage 20
   logic signed [31:0] cos_t;
   logic [15:0]        cos_mag;
   logic signed [16:0] cf_in, cf_ff;
   assign cos_t   = cc_p_ff[gdp_pkg::COS_STEPS-1];
   assign cos_mag = cos_t[31] ? 16'd0 : cos_t[30:15];
   assign cf_in   = ng_ff[13] ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

   // cosine waits for the envelope (stages 21..71)
   logic signed [16:0] cd_ff [51];

   always_ff @(posedge clock) begin
      cf_ff    <= cf_in;
      cd_ff[0] <= cf_ff;
      for (int k = 1; k < 51; k++) cd_ff[k] <= cd_ff[k-1];
   end

   // ---------------- level ----------------

   // cos * env, contrast, luminance, saturate (stages 72..75)
   logic signed [34:0] ce_in, ce_ff;
   logic signed [49:0] pr_in;
   logic signed [47:0] pr_ff;
   logic [47:0]        base;
   logic [55:0]        tot_in, tot_ff;
   logic [9:0]         lvl_hi;
   logic [7:0]         pixel_in, rsp_pixel_ff;

   assign ce_in  = cd_ff[50] * $signed({1'b0, env_ff});
   assign pr_in  = contrast_ff * ce_ff;
   assign base   = pr_ff + gdp_pkg::LEVEL_ONE;
   assign tot_in = 56'(base) * 56'(mean_lum_ff);
   assign lvl_hi = tot_ff[55:46];
   assign pixel_in = (lvl_hi > 10'd255) ? 8'hFF : lvl_hi[7:0];

   always_ff @(posedge clock) begin
      ce_ff        <= ce_in;
      pr_ff        <= pr_in[47:0];
      tot_ff       <= tot_in;
      rsp_pixel_ff <= pixel_in;
   end

   assign rsp_strobe = vld_ff[LAT];
   assign rsp_pixel  = rsp_pixel_ff;

`ifndef SYNTHESIS
   // every result traces back to a start transfer a full latency earlier
   a_strobe_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT+1))
      else $error("result without matching start transfer");

   // zero contrast leaves the mean level
   a_zero_contrast: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && contrast_ff == 16'sd0) |-> rsp_pixel == mean_lum_ff)
      else $error("zero contrast did not give mean level");

   // a vanished envelope leaves the mean level
   a_zero_envelope: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(env_ff == 17'd0, 4)) |-> rsp_pixel == mean_lum_ff)
      else $error("zero envelope did not give mean level");
`endif

endmodule

// ===== bench/tb_gabor_disk_pixel_top.sv =====
// tb_gabor_disk_pixel_top: self-checking bench for the gabor disk pixel pipeline
// a local predictor computes each gray level from the shadow registers; results are
// matched in order against the strobed output; depends on gdp_pkg and gabor_disk_pixel_top
`timescale 1ns / 1ps

module tb_gabor_disk_pixel_top;

   localparam int  PHASE_STEPS  = 1024;
   localparam int  DRAIN_CYCLES = 90;
   localparam longint Q30       = 64'sd1073741824;
   localparam longint TWO_PI28  = 64'sd1686629713;
   localparam longint EXP_M1    = 64'sd395007542;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_x_pos;
   logic signed [15:0] req_y_pos;
   logic               rsp_strobe;
   logic [7:0]         rsp_pixel;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;

   // shadow copy of the configuration registers
   logic [7:0]  sh_mean;
   logic [15:0] sh_contrast;
   logic [15:0] sh_freq;
   logic [15:0] sh_sd;
   logic [15:0] sh_radius;

   logic [7:0]  pending_pixels [$];
   int          mismatches;
   int          idle_pct;

   gabor_disk_pixel_top #(.PHASE_TABLE_SIZE(PHASE_STEPS)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_pos(req_x_pos), .req_y_pos(req_y_pos),
      .rsp_strobe(rsp_strobe), .rsp_pixel(rsp_pixel),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // cos(2*pi*u/65536) in Q30 for one quarter wave
   function automatic longint quarter_cos(longint u);
      longint w, w2, t;
      w  = (u * TWO_PI28) >>> 14;
      w2 = (w * w) >>> 30;
      t  = Q30 - w2 / 56;
      t  = Q30 - ((w2 * t) >>> 30) / 30;
      t  = Q30 - ((w2 * t) >>> 30) / 12;
      t  = Q30 - ((w2 * t) >>> 30) / 2;
      return (t < 0) ? 0 : t;
   endfunction

   // grating cosine in Q1.15 from the wrapped phase
   function automatic longint grating(longint x, longint f);
      longint unsigned frac, idx;
      longint u, q, r, c;
      frac = longint'(x * f) & 64'hFFFFF;
      idx  = (frac * PHASE_STEPS) >> 20;
      u    = longint'((idx << 16) / PHASE_STEPS) & 64'hFFFF;
      q    = u >>> 14;
      r    = u & 64'h3FFF;
      case (q)
         0: c = quarter_cos(r);
         1: c = -quarter_cos(16384 - r);
         2: c = -quarter_cos(r);
         default: c = quarter_cos(16384 - r);
      endcase
      c = (c >= 0) ? (c >>> 15) : -((-c) >>> 15);
      if (c > 32768) c = 32768;
      if (c < -32768) c = -32768;
      return c;
   endfunction

   // exp(-e) with e in Q.12, result in Q16
   function automatic longint falloff(longint unsigned e);
      longint unsigned n;
      longint f, p;
      n = e >> 12;
      if (n >= 12) return 0;
      f = longint'(e & 64'hFFF) << 18;
      p = Q30 - f / 8;
      for (int k = 7; k >= 1; k--) p = Q30 - ((f * p) >>> 30) / k;
      for (longint unsigned i = 0; i < n; i++) p = (p * EXP_M1) >>> 30;
      return p >>> 14;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // expected gray level for one coordinate under the shadow registers
   function automatic logic [7:0] gray_level(logic signed [15:0] xp, logic signed [15:0] yp);
      longint x, y, env, c, prod, total;
      longint unsigned s, rad, r, d, sd, z;
      x   = xp;
      y   = yp;
      s   = longint'(x * x) + longint'(y * y);
      rad = sh_radius;
      if (s < rad * rad) begin
         env = 65536;
      end else begin
         r   = int_sqrt(s);
         d   = r - rad;
         sd  = (sh_sd != 0) ? sh_sd : 1;
         z   = (d << 12) / sd;
         env = falloff((z * z) >> 13);
      end
      c     = grating(x, longint'(sh_freq));
      prod  = longint'($signed(sh_contrast)) * c * env;
      total = (longint'(sh_mean) * ((64'sd1 <<< 46) + prod)) >>> 46;
      if (total > 255) total = 255;
      if (total < 0) total = 0;
      return total[7:0];
   endfunction

   task automatic report(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // record accepted transfers and check each strobed pixel
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset) begin
         if (start && !busy) pending_pixels.push_back(gray_level(req_x_pos, req_y_pos));
         if (rsp_strobe) begin
            if (pending_pixels.size() == 0) begin
               report($sformatf("unexpected pixel %0d", rsp_pixel));
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel !== want)
                  report($sformatf("pixel %0d, expected %0d", rsp_pixel, want));
            end
         end
      end
   end

   // one register write, then the write port goes quiet before the task returns
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         gdp_pkg::REG_MEAN_LUM:    sh_mean     = val[7:0];
         gdp_pkg::REG_CONTRAST:    sh_contrast = val;
         gdp_pkg::REG_FREQUENCY:   sh_freq     = val;
         gdp_pkg::REG_SPREAD_SD:   sh_sd       = val;
         gdp_pkg::REG_DISK_RADIUS: sh_radius   = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_all(logic [7:0] m, logic [15:0] ct, logic [15:0] f,
                          logic [15:0] sd, logic [15:0] rd);
      write_reg(gdp_pkg::REG_MEAN_LUM, {8'd0, m});
      write_reg(gdp_pkg::REG_CONTRAST, ct);
      write_reg(gdp_pkg::REG_FREQUENCY, f);
      write_reg(gdp_pkg::REG_SPREAD_SD, sd);
      write_reg(gdp_pkg::REG_DISK_RADIUS, rd);
   endtask

   // one coordinate transfer, then a random gap
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y);
      logic ok;
      start     <= 1'b1;
      req_x_pos <= x;
      req_y_pos <= y;
      forever begin
         @(negedge clock);
         ok = !busy;
         @(posedge clock);
         if (ok) break;
      end
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // stop sending and let the pipeline empty before touching registers
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      wait (pending_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_values;
      send_point(16'sd0, 16'sd0);
      send_point(16'sd300, 16'sd0);
      drain();
   endtask

   task automatic test_directed;
      set_all(8'd255, 16'h7FFF, 16'd4096, 16'd256, 16'd0);
      send_point(16'sd0, 16'sd0);          // origin with zero radius
      send_point(-16'sd32768, -16'sd32768);
      send_point(16'sd32767, 16'sd32767);
      send_point(16'sd128, 16'sd0);        // half a grating cycle, cosine at its minimum
      send_point(16'sd0, 16'sd900);        // on the vertical axis
      send_point(16'sd0, -16'sd32768);
      drain();
      set_all(8'd200, 16'h8000, 16'd65535, 16'd0, 16'd512);   // zero spread
      send_point(16'sd0, 16'sd0);
      send_point(16'sd511, 16'sd0);
      send_point(16'sd512, 16'sd0);        // just on the disk edge
      send_point(16'sd0, 16'sd513);
      send_point(-16'sd32768, 16'sd32767);
      send_point(16'sd1000, -16'sd700);
      drain();
      // unused register indexes are ignored
      write_reg(3'd5, 16'hFFFF);
      write_reg(3'd6, 16'h1234);
      write_reg(3'd7, 16'hABCD);
      set_all(8'd0, 16'h4000, 16'd0, 16'hFFFF, 16'hFFFF);
      send_point(16'sd32767, -16'sd32768);
      send_point(16'sd100, 16'sd100);
      drain();
      write_reg(gdp_pkg::REG_MEAN_LUM, 16'd255);
      send_point(16'sd32767, -16'sd32768);
      send_point(-16'sd5, 16'sd7);
      drain();
   endtask

   task automatic random_points(int count);
      logic signed [15:0] x, y;
      int span;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1)) begin
            x = 16'($urandom);
            y = 16'($urandom);
         end else begin
            span = 2 * int'(sh_radius) + 4 * int'(sh_sd) + 16;
            if (span > 32767) span = 32767;
            x = 16'($urandom_range(2 * span) - span);
            y = 16'($urandom_range(2 * span) - span);
         end
         send_point(x, y);
      end
   endtask

   task automatic test_random_settings;
      for (int phase = 0; phase < 8; phase++) begin
         set_all(8'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom_range(2048, 1)), 16'($urandom_range(4096)));
         idle_pct = (phase == 3) ? 0 : 9;   // one phase runs back to back
         random_points(45);
         drain();
      end
      set_all(8'd255, 16'h8000, 16'hFFFF, 16'd1, 16'd0);
      random_points(20);
      drain();
      set_all(8'd128, 16'h7FFF, 16'd1, 16'hFFFF, 16'hFFFF);
      random_points(20);
      drain();
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_x_pos  = '0;
      req_y_pos  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      mismatches = 0;
      idle_pct   = 9;
      sh_mean     = gdp_pkg::RST_MEAN_LUM;
      sh_contrast = gdp_pkg::RST_CONTRAST;
      sh_freq     = gdp_pkg::RST_FREQUENCY;
      sh_sd       = gdp_pkg::RST_SPREAD_SD;
      sh_radius   = gdp_pkg::RST_DISK_RADIUS;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_directed();
      test_random_settings();

      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gdp_pkg.sv
rtl/gabor_disk_pixel_top.sv
bench/tb_gabor_disk_pixel_top.sv
